// File: design/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPL(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("check failed");

`define CHK_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// File: design/rbd_pkg.sv
package rbd_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PW         = $clog2(DEPTH);
    localparam int CW         = $clog2(DEPTH + 1);

    localparam logic [3:0] OP_PUSH_BACK  = 4'd0;
    localparam logic [3:0] OP_PUSH_FRONT = 4'd1;
    localparam logic [3:0] OP_POP_BACK   = 4'd2;
    localparam logic [3:0] OP_POP_FRONT  = 4'd3;
    localparam logic [3:0] OP_READ       = 4'd4;
    localparam logic [3:0] OP_INSERT     = 4'd5;
    localparam logic [3:0] OP_ERASE      = 4'd6;
    localparam logic [3:0] OP_ERASE_RNG  = 4'd7;
    localparam logic [3:0] OP_CLEAR      = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [2:0] K_NOP    = 3'd0;
    localparam logic [2:0] K_PUSHB  = 3'd1;
    localparam logic [2:0] K_PUSHF  = 3'd2;
    localparam logic [2:0] K_POPB   = 3'd3;
    localparam logic [2:0] K_POPF   = 3'd4;
    localparam logic [2:0] K_READ   = 3'd5;
    localparam logic [2:0] K_CLEAR  = 3'd6;
    localparam logic [2:0] K_MOVE   = 3'd7;

    // classified request passed front to back
    typedef struct packed {
        logic [2:0]            kind;
        logic [1:0]            status;
        logic [DATA_WIDTH-1:0] value;
        logic [4:0]            idx;
        logic                  ins;
        logic                  shift_front;
        logic [CW-1:0]         gap;
        logic [CW-1:0]         moves;
    } rbd_req_t;

endpackage

// File: design/ring_buffer_deque_unit.sv
// Sequence: the front registers an accepted request, then the back moves from S_IDLE
// through S_RF, S_RB and S_OUT and raises done from a register; this holds for end ops,
// clear and rejected requests, read adds S_RD, and insert and erase step S_MOVE through
// each moved entry (at most 7) and then S_WR. One request in flight; busy drops in the
// done cycle, so a new request may start while done is high. The receiver cannot stall
// done. Reset: asynchronous, active low; deque empty, pointers zero, store unset.
`include "assert_macros.svh"

module ring_buffer_deque_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [3:0]                     operation,
    input  logic [rbd_pkg::DATA_WIDTH-1:0] value,
    input  logic [4:0]                     index,
    input  logic [4:0]                     index_end,
    output logic                           done,
    output logic [rbd_pkg::DATA_WIDTH-1:0] read_value,
    output logic [rbd_pkg::DATA_WIDTH-1:0] front_value,
    output logic [rbd_pkg::DATA_WIDTH-1:0] back_value,
    output logic [4:0]                     count,
    output logic [1:0]                     status
);
    import rbd_pkg::*;

    logic     deq, q_full, q_valid, idle;
    rbd_req_t q_req;
    logic [CW-1:0] cnt_view;

    // front classifies only against a settled count
    assign busy = q_valid || !idle;

    rbd_front u_front
    (
        .clk(clk), .rst_n(rst_n), .start(start && !busy), .operation(operation),
        .value(value), .index(index), .index_end(index_end), .deq(deq),
        .q_full(q_full), .q_valid(q_valid), .q_req(q_req),
        .cnt_next_view(cnt_view)
    );

    rbd_back u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_req(q_req),
        .deq(deq), .idle(idle), .cnt_view(cnt_view), .strobe(done),
        .read_value(read_value), .front_value(front_value),
        .back_value(back_value), .count(count), .status(status)
    );

    `CHK_IMPL(a_cnt_max, clk, rst_n, 1'b1, cnt_view <= CW'(DEPTH))
    `CHK_NEXT(a_acc_busy, clk, rst_n, start && !busy, busy)
    `CHK_IMPL(a_done_range, clk, rst_n, done && status != ST_OK, status != 2'd3)

endmodule

// File: design/rbd_front.sv
module rbd_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [3:0]                    operation,
    input  logic [rbd_pkg::DATA_WIDTH-1:0] value,
    input  logic [4:0]                    index,
    input  logic [4:0]                    index_end,
    input  logic                          deq,
    output logic                          q_full,
    output logic                          q_valid,
    output rbd_pkg::rbd_req_t             q_req,
    input  logic [rbd_pkg::CW-1:0]        cnt_next_view
);
    import rbd_pkg::*;

    // one-entry queue; count view is the back's current count register
    rbd_req_t req_reg;
    logic     vld_reg;
    rbd_req_t cls;
    logic [5:0] c, ix, ie;

    assign q_full  = vld_reg && !deq;
    assign q_valid = vld_reg;
    assign q_req   = req_reg;

    always_comb
    begin
        c  = 6'(cnt_next_view);
        ix = 6'(index);
        ie = 6'(index_end);
        cls = '0;
        cls.value = value;
        cls.idx = index;
        cls.kind = K_NOP;
        cls.status = ST_OK;
        unique case (operation)
            OP_PUSH_BACK:
            begin
                if (c >= 6'(DEPTH)) cls.status = ST_FULL;
                else cls.kind = K_PUSHB;
            end
            OP_PUSH_FRONT:
            begin
                if (c >= 6'(DEPTH)) cls.status = ST_FULL;
                else cls.kind = K_PUSHF;
            end
            OP_POP_BACK:
            begin
                if (c == 6'd0) cls.status = ST_RANGE;
                else cls.kind = K_POPB;
            end
            OP_POP_FRONT:
            begin
                if (c == 6'd0) cls.status = ST_RANGE;
                else cls.kind = K_POPF;
            end
            OP_READ:
            begin
                if (ix >= c) cls.status = ST_RANGE;
                else cls.kind = K_READ;
            end
            OP_INSERT:
            begin
                if (ix > c) cls.status = ST_RANGE;
                else if (c >= 6'(DEPTH)) cls.status = ST_FULL;
                else
                begin
                    cls.kind = K_MOVE;
                    cls.ins = 1'b1;
                    cls.gap = CW'(1);
                    cls.shift_front = ix < (c - ix);
                    cls.moves = cls.shift_front ? CW'(ix) : CW'(c - ix);
                end
            end
            OP_ERASE:
            begin
                if (ix >= c) cls.status = ST_RANGE;
                else
                begin
                    cls.kind = K_MOVE;
                    cls.gap = CW'(1);
                    cls.shift_front = ix < (c - ix);
                    cls.moves = cls.shift_front ? CW'(ix) : CW'(c - ix - 6'd1);
                end
            end
            OP_ERASE_RNG:
            begin
                if (ix > ie || ie > c) cls.status = ST_RANGE;
                else if (ix != ie)
                begin
                    cls.kind = K_MOVE;
                    cls.gap = CW'(ie - ix);
                    cls.shift_front = ix < (c - ie);
                    cls.moves = cls.shift_front ? CW'(ix) : CW'(c - ie);
                end
            end
            OP_CLEAR: cls.kind = K_CLEAR;
            default: cls.kind = K_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (start && !q_full)
            vld_reg <= 1'b1;
        else if (deq)
            vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (start && !q_full)
            req_reg <= cls;
    end

endmodule

// File: design/rbd_back.sv
module rbd_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  rbd_pkg::rbd_req_t              q_req,
    output logic                           deq,
    output logic                           idle,
    output logic [rbd_pkg::CW-1:0]         cnt_view,
    output logic                           strobe,
    output logic [rbd_pkg::DATA_WIDTH-1:0] read_value,
    output logic [rbd_pkg::DATA_WIDTH-1:0] front_value,
    output logic [rbd_pkg::DATA_WIDTH-1:0] back_value,
    output logic [4:0]                     count,
    output logic [1:0]                     status
);
    import rbd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOVE = 3'd1;
    localparam logic [2:0] S_WR   = 3'd2;
    localparam logic [2:0] S_RF   = 3'd3;
    localparam logic [2:0] S_RB   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_RD   = 3'd6;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [2:0]            st_reg, st_next;
    logic [PW-1:0]         head_reg, head_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    rbd_req_t              cur_reg;
    logic [CW-1:0]         step_reg, step_next;
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic [DATA_WIDTH-1:0] rv_reg, rv_next, fv_reg, fv_next;
    logic [DATA_WIDTH-1:0] bv_reg, bv_next;
    logic [1:0]            stat_reg, stat_next;
    logic                  stb_reg, stb_next;
    logic                  rd_en, wr_en;
    logic [PW-1:0]         rd_addr, wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  mv_pend_reg, mv_pend_next;
    logic [PW-1:0]         mv_dst_reg, mv_dst_next;

    function automatic logic [PW-1:0] slot(input logic [PW-1:0] h, input logic [CW:0] l);
        slot = h + PW'(l);
    endfunction

    assign deq = q_valid && (st_reg == S_IDLE);
    assign idle = (st_reg == S_IDLE) && !q_valid;
    assign cnt_view = cnt_reg;
    assign strobe = stb_reg;
    assign read_value = rv_reg;
    assign front_value = fv_reg;
    assign back_value = bv_reg;
    assign count = 5'(cnt_reg);
    assign status = stat_reg;

    always_comb
    begin
        logic [CW:0] src;
        logic [CW:0] dst;
        st_next = st_reg;
        head_next = head_reg;
        cnt_next = cnt_reg;
        step_next = step_reg;
        rv_next = rv_reg;
        fv_next = fv_reg;
        bv_next = bv_reg;
        stat_next = stat_reg;
        stb_next = 1'b0;
        rd_en = 1'b0;
        wr_en = 1'b0;
        rd_addr = '0;
        wr_addr = '0;
        wr_data = cur_reg.value;
        mv_pend_next = 1'b0;
        mv_dst_next = mv_dst_reg;
        src = '0;
        dst = '0;
        if (mv_pend_reg)
        begin
            wr_en = 1'b1;
            wr_addr = mv_dst_reg;
            wr_data = rdata_reg;
        end
        unique case (st_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    stat_next = q_req.status;
                    rv_next = '0;
                    step_next = '0;
                    st_next = S_RF;
                    unique case (q_req.kind)
                        K_PUSHB:
                        begin
                            wr_en = 1'b1;
                            wr_addr = slot(head_reg, (CW+1)'(cnt_reg));
                            wr_data = q_req.value;
                            cnt_next = cnt_reg + CW'(1);
                        end
                        K_PUSHF:
                        begin
                            wr_en = 1'b1;
                            wr_addr = head_reg - PW'(1);
                            wr_data = q_req.value;
                            head_next = head_reg - PW'(1);
                            cnt_next = cnt_reg + CW'(1);
                        end
                        K_POPB: cnt_next = cnt_reg - CW'(1);
                        K_POPF:
                        begin
                            head_next = head_reg + PW'(1);
                            cnt_next = cnt_reg - CW'(1);
                        end
                        K_READ:
                        begin
                            rd_en = 1'b1;
                            rd_addr = slot(head_reg, (CW+1)'(q_req.idx));
                            st_next = S_RD;
                        end
                        K_CLEAR:
                        begin
                            head_next = '0;
                            cnt_next = '0;
                        end
                        K_MOVE:
                        begin
                            if (q_req.ins && q_req.shift_front)
                                head_next = head_reg - PW'(1);
                            st_next = S_MOVE;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD:
            begin
                rv_next = rdata_reg;
                st_next = S_RF;
            end
            S_MOVE:
            begin
                if (step_reg == cur_reg.moves)
                    st_next = S_WR;
                else
                begin
                    step_next = step_reg + CW'(1);
                    if (cur_reg.ins)
                    begin
                        if (cur_reg.shift_front)
                        begin
                            src = (CW+1)'(step_reg) + 1'b1;
                            dst = (CW+1)'(step_reg);
                        end
                        else
                        begin
                            src = (CW+1)'(cnt_reg) - (CW+1)'(step_reg) - 1'b1;
                            dst = (CW+1)'(cnt_reg) - (CW+1)'(step_reg);
                        end
                    end
                    else if (cur_reg.shift_front)
                    begin
                        src = (CW+1)'(cur_reg.idx) - (CW+1)'(step_reg) - 1'b1;
                        dst = src + (CW+1)'(cur_reg.gap);
                    end
                    else
                    begin
                        src = (CW+1)'(cur_reg.idx) + (CW+1)'(cur_reg.gap)
                            + (CW+1)'(step_reg);
                        dst = src - (CW+1)'(cur_reg.gap);
                    end
                    rd_en = 1'b1;
                    rd_addr = slot(head_reg, src);
                    mv_pend_next = 1'b1;
                    mv_dst_next = slot(head_reg, dst);
                end
            end
            S_WR:
            begin
                if (cur_reg.ins)
                begin
                    wr_en = 1'b1;
                    wr_addr = slot(head_reg, (CW+1)'(cur_reg.idx));
                    wr_data = cur_reg.value;
                    cnt_next = cnt_reg + CW'(1);
                end
                else
                begin
                    if (cur_reg.shift_front)
                        head_next = head_reg + PW'(cur_reg.gap);
                    cnt_next = cnt_reg - cur_reg.gap;
                end
                st_next = S_RF;
            end
            S_RF:
            begin
                rd_en = 1'b1;
                rd_addr = head_reg;
                st_next = S_RB;
            end
            S_RB:
            begin
                rd_en = 1'b1;
                rd_addr = slot(head_reg, (CW+1)'(cnt_reg) - 1'b1);
                fv_next = (cnt_reg == '0) ? '0 : rdata_reg;
                st_next = S_OUT;
            end
            S_OUT:
            begin
                bv_next = (cnt_reg == '0) ? '0 : rdata_reg;
                stb_next = 1'b1;
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (deq)
            cur_reg <= q_req;
        step_reg <= step_next;
        rv_reg <= rv_next;
        fv_reg <= fv_next;
        bv_reg <= bv_next;
        stat_reg <= stat_next;
        mv_dst_reg <= mv_dst_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            head_reg <= '0;
            cnt_reg <= '0;
            stb_reg <= 1'b0;
            mv_pend_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            head_reg <= head_next;
            cnt_reg <= cnt_next;
            stb_reg <= stb_next;
            mv_pend_reg <= mv_pend_next;
        end
    end

endmodule
